// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define UVLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define UVLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well.
`define UVLT_ASSERT_NEXT_ALL(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/uvlt_pkg.sv =====
// ---------------------------------------------------------------------------
// UV lamp timer package
// Constants, key codes and types shared by the timer controller and checker.
// ---------------------------------------------------------------------------
`default_nettype none

package uvlt_pkg;

    // PWM runs over PWM_STEPS + 1 phases; levels share the phase width
    localparam int PWM_STEPS = 16;
    localparam int LVL_W     = $clog2(PWM_STEPS + 1);

    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(PWM_STEPS);
    localparam logic [LVL_W-1:0] LVL_HALF = LVL_W'(PWM_STEPS / 2);
    localparam logic [LVL_W-1:0] LVL_OFF  = '0;

    // Key scan codes
    localparam logic [7:0] KEY_LONG  = 8'h47;
    localparam logic [7:0] KEY_MID   = 8'h5F;
    localparam logic [7:0] KEY_SHORT = 8'h77;
    localparam int         KEY_DOWN_BIT = 6;

    // Run lengths in seconds
    localparam logic [6:0] SECS_LONG  = 7'd120;
    localparam logic [6:0] SECS_MID   = 7'd60;
    localparam logic [6:0] SECS_SHORT = 7'd30;

    localparam logic [9:0] FREEZE_LIMIT = 10'd120;
    localparam logic [9:0] HIDDEN_COUNT = 10'd888;

    // Stream widths
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    typedef enum logic [1:0] {
        MODE_WAIT = 2'd0,
        MODE_STOP = 2'd1,
        MODE_RUN  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CFG_TICKS_PER_MS   = 2'd0,
        CFG_MS_PER_POLL    = 2'd1,
        CFG_MS_PER_SECOND  = 2'd2,
        CFG_PRESENCE_LIMIT = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== hw/rtl/uv_lamp_timer_controller.sv =====
// ---------------------------------------------------------------------------
// UV lamp timer controller
// Tick-driven lamp timer: dividers, soft-start PWM, countdown, keys, presence.
// ---------------------------------------------------------------------------
// Each input transaction is one base tick carrying the sampled key scan byte
// and the presence level; each tick yields exactly one output transaction
// with the lamp drive, the seconds left, a display refresh pulse and the run
// mode. The block takes one tick per clock cycle while results are taken.
// An accepted tick sits in the input register; from there all timer, key
// and presence work is done in one pass of shallow counter and compare
// logic into the result register, which is offered downstream. While a
// result waits for the downstream side the input register still takes one
// more tick, then the input stalls until the waiting result is taken. Write
// configuration only while no tick is in flight.
`default_nettype none

module uv_lamp_timer_controller (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Input ticks. tdata: [7:0] key_code, [8] presence, [15:9] zero
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [uvlt_pkg::IN_W-1:0]  s_axis_tdata,
    // Results. tdata: [0] lamp_drive, [10:1] seconds_left, [11] refresh,
    // [13:12] run_mode, [15:14] zero
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [uvlt_pkg::OUT_W-1:0]      m_axis_tdata,
    // Configuration write port
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [11:0]                i_cfg_data
);

    localparam int LW = uvlt_pkg::LVL_W;

    // Configuration registers
    logic [7:0]  r_ticks_per_ms;
    logic [7:0]  r_ms_per_poll;
    logic [11:0] r_ms_per_second;
    logic [7:0]  r_presence_limit;

    // Handshake stages
    logic        r_in_valid;
    logic [7:0]  r_in_key;
    logic        r_in_pres;
    logic        r_out_valid;
    logic [uvlt_pkg::OUT_W-1:0] r_out_data;

    // Timer state
    logic [7:0]  r_tick,     n_tick;
    logic [7:0]  r_poll,     n_poll;
    logic [11:0] r_sec,      n_sec;
    logic [LW-1:0] r_phase,  n_phase;
    logic [LW-1:0] r_target, n_target;
    logic [LW-1:0] r_ramp,   n_ramp;
    logic [9:0]  r_rem,      n_rem;
    logic [6:0]  r_saved,    n_saved;
    uvlt_pkg::t_mode r_mode, n_mode;
    logic [7:0]  r_deb,      n_deb;
    logic [7:0]  r_last_key, n_last_key;
    logic [3:0]  r_combo,    n_combo;
    logic        r_refresh,  n_refresh;
    logic        n_lamp;

    logic w_adv;
    logic w_fire;

    // Advance the result stage when it is empty or being drained
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_ms   <= 8'd20;
            r_ms_per_poll    <= 8'd5;
            r_ms_per_second  <= 12'd1000;
            r_presence_limit <= 8'd20;
        end else if (i_cfg_we) begin
            unique case (uvlt_pkg::t_cfg_idx'(i_cfg_idx))
                uvlt_pkg::CFG_TICKS_PER_MS:   r_ticks_per_ms   <= i_cfg_data[7:0];
                uvlt_pkg::CFG_MS_PER_POLL:    r_ms_per_poll    <= i_cfg_data[7:0];
                uvlt_pkg::CFG_MS_PER_SECOND:  r_ms_per_second  <= i_cfg_data;
                uvlt_pkg::CFG_PRESENCE_LIMIT: r_presence_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_key  <= s_axis_tdata[7:0];
            r_in_pres <= s_axis_tdata[8];
        end
    end

    // One tick of work: dividers, PWM, then poll work on keys and presence.
    // Later steps see the values earlier steps produced within the same tick.
    always_comb begin
        logic poll;
        logic release_seen;
        logic [3:0] combo_s;

        n_tick       = r_tick;
        n_poll       = r_poll;
        n_sec        = r_sec;
        n_phase      = r_phase;
        n_target     = r_target;
        n_ramp       = r_ramp;
        n_rem        = r_rem;
        n_saved      = r_saved;
        n_mode       = r_mode;
        n_deb        = r_deb;
        n_last_key   = r_last_key;
        n_combo      = r_combo;
        n_refresh    = r_refresh;
        poll         = 1'b0;
        release_seen = 1'b0;
        combo_s      = '0;

        // Cascaded dividers: tick -> ms -> poll / second
        if (r_tick < r_ticks_per_ms) begin
            n_tick = r_tick + 8'd1;
        end else begin
            n_tick = '0;
            if (r_poll < r_ms_per_poll) begin
                n_poll = r_poll + 8'd1;
            end else begin
                n_poll = '0;
                poll   = 1'b1;
                // Soft start: step the ramp towards the target once per poll
                if (r_ramp < r_target) begin
                    n_ramp = r_ramp + LW'(1);
                end
            end
            if (r_sec < r_ms_per_second) begin
                n_sec = r_sec + 12'd1;
            end else begin
                n_sec = '0;
                // Count down only at or below the freeze point
                if ((r_rem <= uvlt_pkg::FREEZE_LIMIT) && (r_rem != '0)) begin
                    n_rem     = r_rem - 10'd1;
                    n_refresh = 1'b1;
                    if (n_rem == '0) begin
                        n_mode   = uvlt_pkg::MODE_STOP;
                        n_target = uvlt_pkg::LVL_OFF;
                        n_combo  = '0;
                    end
                end
            end
        end

        // PWM phase wraps after PWM_STEPS
        if (r_phase < uvlt_pkg::LVL_FULL) begin
            n_phase = r_phase + LW'(1);
        end else begin
            n_phase = '0;
        end
        if (n_target == uvlt_pkg::LVL_OFF) begin
            n_ramp = '0;
        end
        // Lamp is sampled before the poll work below
        n_lamp = (n_phase < n_ramp);

        if (poll) begin
            // Sequence step as left by a countdown ending on this tick
            combo_s      = n_combo;
            release_seen = !r_in_key[uvlt_pkg::KEY_DOWN_BIT] &&
                           r_last_key[uvlt_pkg::KEY_DOWN_BIT];
            if (release_seen && ((r_last_key == uvlt_pkg::KEY_LONG) ||
                                 (r_last_key == uvlt_pkg::KEY_MID)  ||
                                 (r_last_key == uvlt_pkg::KEY_SHORT))) begin
                // Toggle: stop a run in progress, else start one
                n_tick    = '0;
                n_sec     = '0;
                n_refresh = 1'b1;
                if (n_rem != '0) begin
                    n_target = uvlt_pkg::LVL_OFF;
                    n_rem    = '0;
                    n_mode   = uvlt_pkg::MODE_STOP;
                end else begin
                    n_mode = uvlt_pkg::MODE_RUN;
                    if (r_last_key == uvlt_pkg::KEY_LONG) begin
                        n_target = uvlt_pkg::LVL_HALF;
                        n_saved  = uvlt_pkg::SECS_LONG;
                    end else if (r_last_key == uvlt_pkg::KEY_MID) begin
                        n_target = uvlt_pkg::LVL_FULL;
                        n_saved  = uvlt_pkg::SECS_MID;
                    end else begin
                        n_target = uvlt_pkg::LVL_FULL;
                        n_saved  = uvlt_pkg::SECS_SHORT;
                    end
                    n_rem = {3'b000, n_saved};
                end

                // Hidden sequence: long long short short mid mid long short mid
                if (r_last_key == uvlt_pkg::KEY_LONG) begin
                    n_combo = (combo_s == 4'd0) ? 4'd1 :
                              (combo_s == 4'd1) ? 4'd2 :
                              (combo_s == 4'd6) ? 4'd7 : 4'd0;
                end else if (r_last_key == uvlt_pkg::KEY_MID) begin
                    n_combo = (combo_s == 4'd4) ? 4'd5 :
                              (combo_s == 4'd5) ? 4'd6 : 4'd0;
                    if (combo_s == 4'd8) begin
                        n_rem = uvlt_pkg::HIDDEN_COUNT;
                    end
                end else begin
                    n_combo = (combo_s == 4'd2) ? 4'd3 :
                              (combo_s == 4'd3) ? 4'd4 :
                              (combo_s == 4'd7) ? 4'd8 : 4'd0;
                end
            end
            n_last_key = r_in_key;

            // Presence debounce, ignored during a key-started run
            if ((n_mode == uvlt_pkg::MODE_WAIT) || (n_mode == uvlt_pkg::MODE_STOP)) begin
                if (r_in_pres) begin
                    if (r_deb < r_presence_limit) begin
                        n_deb = r_deb + 8'd1;
                        if ((n_deb == r_presence_limit) &&
                            (n_mode == uvlt_pkg::MODE_WAIT)) begin
                            n_tick    = '0;
                            n_sec     = '0;
                            n_refresh = 1'b1;
                            n_rem     = {3'b000, n_saved};
                            n_target  = uvlt_pkg::LVL_FULL;
                        end
                    end
                end else if (r_deb != '0) begin
                    n_deb = r_deb - 8'd1;
                    if (n_deb == '0) begin
                        n_mode    = uvlt_pkg::MODE_WAIT;
                        n_tick    = '0;
                        n_sec     = '0;
                        n_refresh = 1'b1;
                        n_rem     = '0;
                        n_target  = uvlt_pkg::LVL_OFF;
                    end
                end
            end
        end
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_poll      <= '0;
            r_sec       <= '0;
            r_phase     <= '0;
            r_target    <= '0;
            r_ramp      <= '0;
            r_rem       <= '0;
            r_saved     <= uvlt_pkg::SECS_MID;
            r_mode      <= uvlt_pkg::MODE_WAIT;
            r_deb       <= 8'd10;
            r_last_key  <= '0;
            r_combo     <= '0;
            r_refresh   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_tick     <= n_tick;
                r_poll     <= n_poll;
                r_sec      <= n_sec;
                r_phase    <= n_phase;
                r_target   <= n_target;
                r_ramp     <= n_ramp;
                r_rem      <= n_rem;
                r_saved    <= n_saved;
                r_mode     <= n_mode;
                r_deb      <= n_deb;
                r_last_key <= n_last_key;
                r_combo    <= n_combo;
                // Refresh is a one-tick pulse
                r_refresh  <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {2'b00, 2'(n_mode), n_refresh, n_rem, n_lamp};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/uvlt_checker.sv =====
// ---------------------------------------------------------------------------
// UV lamp timer checker
// Port-level assertions on the timer controller, bound to the controller.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module uvlt_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic [uvlt_pkg::IN_W-1:0]  s_axis_tdata,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [uvlt_pkg::OUT_W-1:0] m_axis_tdata
);

    logic [9:0] w_secs;
    logic [1:0] w_mode;
    logic       w_in_xfer;

    assign w_secs    = m_axis_tdata[10:1];
    assign w_mode    = m_axis_tdata[13:12];
    assign w_in_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tdata[15:9] == '0);

    // Drop all results on reset
    `UVLT_ASSERT_NEXT_ALL(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid, "result valid after reset")

    // Mode code stays within its three values
    `UVLT_ASSERT_NOW(a_mode_code, i_clk, i_rst_n, m_axis_tvalid,
        (w_mode == 2'(uvlt_pkg::MODE_WAIT)) || (w_mode == 2'(uvlt_pkg::MODE_STOP)) ||
        (w_mode == 2'(uvlt_pkg::MODE_RUN)), "run mode out of range")

    // Count is either at most the freeze limit or the hidden value
    `UVLT_ASSERT_NOW(a_secs_range, i_clk, i_rst_n, m_axis_tvalid,
        (w_secs <= uvlt_pkg::FREEZE_LIMIT) || (w_secs == uvlt_pkg::HIDDEN_COUNT),
        "seconds left out of range")

    // A stalled result holds
    `UVLT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // An accepted tick with the output free passes the input register, then shows up as a valid result
    `UVLT_ASSERT_NEXT(a_latency, i_clk, i_rst_n, w_in_xfer && !m_axis_tvalid,
        ##1 m_axis_tvalid, "accepted tick produced no result")

endmodule

bind uv_lamp_timer_controller uvlt_checker u_uvlt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
